// ----- rtl/eth_ipv4_udp_port_filter_defines.svh -----
// Assertion macros used by the checker of the UDP port filter
`ifndef ETH_IPV4_UDP_PORT_FILTER_DEFINES_SVH
`define ETH_IPV4_UDP_PORT_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define EUPF_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define EUPF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/eupf_pkg.sv -----
// Types and constants of the Ethernet/IPv4/UDP port filter
`default_nettype none

package eupf_pkg;

	// Frame position counter and its saturation point
	localparam int unsigned POS_W           = 16;
	localparam int unsigned MAX_FRAME_BYTES = 2048;

	// Header layout and field codes
	localparam logic [7:0] ETHERTYPE_HI   = 8'h08;
	localparam logic [7:0] ETHERTYPE_LO   = 8'h00;
	localparam logic [7:0] PROTO_UDP      = 8'd17;
	localparam int unsigned ETH_HDR_BYTES = 14;
	localparam int unsigned IP_HDR_BYTES  = 20;
	localparam int unsigned UDP_HDR_BYTES = 8;
	localparam int unsigned POS_ETYPE_LO  = 13;
	localparam int unsigned POS_IHL       = 14;
	localparam int unsigned POS_PROTO     = 23;

	// UDP header start, wide enough for 14 + 4 * 15
	localparam int unsigned UDP_START_W = 7;
	localparam logic [UDP_START_W-1:0] UDP_START_RST =
		UDP_START_W'(ETH_HDR_BYTES + IP_HDR_BYTES);

	// Configuration registers
	localparam int unsigned CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_WANT_DEST_PORT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WANT_SOURCE_PORT = CFG_IDX_W'(1);
	localparam logic [15:0] RST_WANT_DEST_PORT   = 16'd1068;
	localparam logic [15:0] RST_WANT_SOURCE_PORT = 16'd1067;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_end;
	} out_item_t;

	typedef struct packed {
		logic [15:0] want_dest_port;
		logic [15:0] want_source_port;
	} cfg_t;

	typedef struct packed {
		logic     valid;
		in_item_t item;
	} stage_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/eth_ipv4_udp_port_filter.sv -----
// Top level of the Ethernet/IPv4/UDP port filter
// Takes one frame byte per clock unless out stalls, and passes the UDP payload
// of frames whose ethertype is IPv4, protocol is UDP and ports equal the
// configured source and destination ports; the passed byte that ends its frame
// carries payload_end. A passed byte goes through the input register, then the
// result register, before it is offered on out; the header checks are
// combinational compares on the frame position counter. Bytes beyond the
// saturation length are dropped. Configuration writes are always accepted and
// belong to idle periods between frames.
`default_nettype none

module eth_ipv4_udp_port_filter
	import eupf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire in_item_t             in_data,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      out_item_t            out_data,
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	cfg_t   cfg;
	stage_t s1;
	res_t   res;
	logic   advance;

	eupf_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	eupf_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.s1       (s1)
	);

	eupf_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.s1      (s1),
		.advance (advance),
		.cfg     (cfg),
		.res     (res)
	);

	eupf_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ----- rtl/eupf_cfg_regs.sv -----
// Configuration registers of the UDP port filter
`default_nettype none

module eupf_cfg_regs
	import eupf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data,
	output      cfg_t                 cfg
);

	cfg_t cfg_q;

	// Always take a write; unknown indexes are dropped
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.want_dest_port   <= RST_WANT_DEST_PORT;
			cfg_q.want_source_port <= RST_WANT_SOURCE_PORT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WANT_DEST_PORT:   cfg_q.want_dest_port   <= cfg_data;
				REG_WANT_SOURCE_PORT: cfg_q.want_source_port <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/eupf_in_reg.sv -----
// Input register stage of the UDP port filter
`default_nettype none

module eupf_in_reg
	import eupf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output      logic     in_ready,
	input  wire in_item_t in_data,
	input  wire logic     advance,
	output      stage_t   s1
);

	logic     valid_s1;
	in_item_t item_s1;

	// Free when empty or when the held request moves on this cycle
	assign in_ready = !valid_s1 || advance;
	assign s1       = '{valid: valid_s1, item: item_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/eupf_parser.sv -----
// Header tracking and match decision of the UDP port filter
`default_nettype none

module eupf_parser
	import eupf_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire stage_t s1,
	input  wire logic   advance,
	input  wire cfg_t   cfg,
	output      res_t   res
);

	logic [POS_W-1:0]       pos_q;
	logic [7:0]             prev_q;
	logic                   eth_ok_q;
	logic                   proto_ok_q;
	logic [UDP_START_W-1:0] udp_start_q;
	logic                   src_ok_q;
	logic                   dst_ok_q;

	logic                   take;
	logic                   live;
	logic [7:0]             b;
	logic [15:0]            word;
	logic                   eth_ok_n;
	logic                   proto_ok_n;
	logic [UDP_START_W-1:0] udp_start_n;
	logic                   src_ok_n;
	logic                   dst_ok_n;
	logic [POS_W-1:0]       udp_ext;
	logic                   hit;

	assign take = s1.valid && advance;
	assign b    = s1.item.frame_byte;
	assign word = {prev_q, b};
	assign live = pos_q < POS_W'(MAX_FRAME_BYTES);

	// Update the header checks for this byte
	always_comb begin
		eth_ok_n    = eth_ok_q;
		proto_ok_n  = proto_ok_q;
		udp_start_n = udp_start_q;
		src_ok_n    = src_ok_q;
		dst_ok_n    = dst_ok_q;
		if (live) begin
			if (pos_q == POS_W'(POS_ETYPE_LO)) begin
				eth_ok_n = (prev_q == ETHERTYPE_HI) && (b == ETHERTYPE_LO);
			end
			if (pos_q == POS_W'(POS_IHL)) begin
				udp_start_n = UDP_START_W'(ETH_HDR_BYTES) + {1'b0, b[3:0], 2'b00};
			end
			if (pos_q == POS_W'(POS_PROTO)) begin
				proto_ok_n = (b == PROTO_UDP);
			end
		end
		udp_ext = POS_W'(udp_start_n);
		if (live && (pos_q == udp_ext + POS_W'(1))) begin
			src_ok_n = (word == cfg.want_source_port);
		end
		if (live && (pos_q == udp_ext + POS_W'(3))) begin
			dst_ok_n = (word == cfg.want_dest_port);
		end
	end

	// Pass bytes after the UDP header once every check holds
	assign hit = live && (pos_q >= udp_ext + POS_W'(UDP_HDR_BYTES))
		&& eth_ok_n && proto_ok_n && src_ok_n && dst_ok_n;

	assign res.valid             = take && hit;
	assign res.item.payload_byte = b;
	assign res.item.payload_end  = s1.item.frame_end;

	// Advance the frame state; restart on the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			prev_q      <= '0;
			eth_ok_q    <= 1'b0;
			proto_ok_q  <= 1'b0;
			udp_start_q <= UDP_START_RST;
			src_ok_q    <= 1'b0;
			dst_ok_q    <= 1'b0;
		end else if (take) begin
			prev_q <= b;
			if (s1.item.frame_end) begin
				pos_q       <= '0;
				eth_ok_q    <= 1'b0;
				proto_ok_q  <= 1'b0;
				udp_start_q <= UDP_START_RST;
				src_ok_q    <= 1'b0;
				dst_ok_q    <= 1'b0;
			end else begin
				if (live) begin
					pos_q <= pos_q + POS_W'(1);
				end
				eth_ok_q    <= eth_ok_n;
				proto_ok_q  <= proto_ok_n;
				udp_start_q <= udp_start_n;
				src_ok_q    <= src_ok_n;
				dst_ok_q    <= dst_ok_n;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/eupf_out_reg.sv -----
// Result register of the UDP port filter
`default_nettype none

module eupf_out_reg
	import eupf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire res_t      res,
	output      logic      advance,
	output      logic      out_valid,
	input  wire logic      out_ready,
	output      out_item_t out_data
);

	logic      valid_q;
	out_item_t item_q;

	// Move on when the register is empty or being drained
	assign advance   = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res.valid;
		end
	end

	// Hold the payload while stalled
	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			item_q <= res.item;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/eupf_checker.sv -----
// Port-level checker of the UDP port filter, bound to the top level
`default_nettype none
`include "eth_ipv4_udp_port_filter_defines.svh"

module eupf_checker
	import eupf_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data,
	input wire logic      cfg_valid,
	input wire logic      cfg_ready
);

	logic out_stall;

	assign out_stall = out_valid && !out_ready;

	// A stalled result holds its value
	`EUPF_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "result changed")

	// An empty result register never blocks a request
	`EUPF_ASSERT(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

	// Draining the result frees the input side in the same cycle
	`EUPF_ASSERT(a_ready_when_drain, out_ready, in_ready, "input stalled while output drains")

	// Configuration writes are never held off
	`EUPF_ASSERT(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind eth_ipv4_udp_port_filter eupf_checker u_checker (.*);

`default_nettype wire

// ----- dv/tb_top.sv -----
// Testbench of the Ethernet/IPv4/UDP port filter: frames in, payload bytes checked out
module tb_top
	import eupf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] frame_q_t[$];

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_WANT_SOURCE_PORT + 1'b1;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned SETTLE_CYCLES = 6;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	// Idle rates of both sides, in percent of cycles
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned fault_count = 0;
	bit          paused_once = 1'b0;

	// Payload bytes the filter is due to pass, oldest first
	out_item_t payload_due[$];

	// Shadow of the filter state and its port registers
	int unsigned     frame_pos = 0;
	logic [7:0]      last_byte = '0;
	logic            etype_ok = 1'b0;
	logic            proto_ok = 1'b0;
	logic [UDP_START_W-1:0] hdr_start = UDP_START_RST;
	logic            src_ok = 1'b0;
	logic            dst_ok = 1'b0;
	logic [15:0]     want_dst = RST_WANT_DEST_PORT;
	logic [15:0]     want_src = RST_WANT_SOURCE_PORT;

	eth_ipv4_udp_port_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Stall the receiver at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
	end

	// Advance the shadow state by one accepted byte and queue any payload byte
	function automatic void track_frame_byte(input in_item_t it);
		logic [15:0] word;
		out_item_t   res;
		int unsigned pos;
		pos = frame_pos;
		if (pos < MAX_FRAME_BYTES) begin
			word = {last_byte, it.frame_byte};
			if (pos == POS_ETYPE_LO)
				etype_ok = (last_byte == ETHERTYPE_HI) && (it.frame_byte == ETHERTYPE_LO);
			if (pos == POS_IHL)
				hdr_start = UDP_START_W'(ETH_HDR_BYTES + 4 * it.frame_byte[3:0]);
			if (pos == POS_PROTO)
				proto_ok = (it.frame_byte == PROTO_UDP);
			if (pos == hdr_start + 1)
				src_ok = (word == want_src);
			if (pos == hdr_start + 3)
				dst_ok = (word == want_dst);
			if (pos >= hdr_start + UDP_HDR_BYTES && etype_ok && proto_ok && src_ok && dst_ok) begin
				res.payload_byte = it.frame_byte;
				res.payload_end  = it.frame_end;
				payload_due.push_back(res);
			end
			frame_pos = pos + 1;
		end
		last_byte = it.frame_byte;
		// Restart the header walk at frame end
		if (it.frame_end) begin
			frame_pos = 0;
			etype_ok  = 1'b0;
			proto_ok  = 1'b0;
			hdr_start = UDP_START_RST;
			src_ok    = 1'b0;
			dst_ok    = 1'b0;
		end
	endfunction

	// Compare each passed byte with the oldest one due
	always @(posedge clk) begin : check_payload
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (payload_due.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("unexpected payload byte %h end %b", out_data.payload_byte,
						out_data.payload_end);
			end else begin
				want = payload_due.pop_front();
				if (out_data.payload_byte !== want.payload_byte
						|| out_data.payload_end !== want.payload_end) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("payload mismatch: expected byte %h end %b, got byte %h end %b",
							want.payload_byte, want.payload_end,
							out_data.payload_byte, out_data.payload_end);
				end
			end
		end
	end

	// Offer one frame byte, idling first at random, and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic last);
		in_item_t it;
		it.frame_byte = b;
		it.frame_end  = last;
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		track_frame_byte(it);
	endtask

	task automatic send_frame(input frame_q_t f);
		foreach (f[i])
			send_byte(f[i], i == f.size() - 1);
	endtask

	// Drop valid and wait until every due byte has come and the pipeline is empty
	task automatic drain_payload();
		@(negedge clk);
		in_valid <= 1'b0;
		while (payload_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one port register while the filter is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		drain_payload();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_WANT_DEST_PORT)
			want_dst = value;
		else if (idx == REG_WANT_SOURCE_PORT)
			want_src = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Build an IPv4/UDP frame with the given IHL, ports and payload length
	function automatic frame_q_t build_frame(input int unsigned ihl, input logic [15:0] src,
			input logic [15:0] dst, input int unsigned pay_len);
		frame_q_t    f;
		int unsigned hs;
		int unsigned total;
		hs    = ETH_HDR_BYTES + 4 * ihl;
		total = hs + UDP_HDR_BYTES + pay_len;
		if (total < POS_PROTO + 1)
			total = POS_PROTO + 1;
		for (int unsigned i = 0; i < total; i++)
			f.push_back(8'($urandom));
		f[POS_ETYPE_LO - 1] = ETHERTYPE_HI;
		f[POS_ETYPE_LO]     = ETHERTYPE_LO;
		f[POS_IHL]          = {4'($urandom), 4'(ihl)};
		f[POS_PROTO]        = PROTO_UDP;
		// Ports last, so a short IHL lets them overlay the IP header
		f[hs]     = src[15:8];
		f[hs + 1] = src[7:0];
		f[hs + 2] = dst[15:8];
		f[hs + 3] = dst[7:0];
		return f;
	endfunction

	task automatic test_reset_ports();
		frame_q_t f;
		f = build_frame(5, RST_WANT_SOURCE_PORT, RST_WANT_DEST_PORT, 3);
		f[f.size() - 3] = 8'h00;
		f[f.size() - 2] = 8'hFF;
		send_frame(f);
	endtask

	task automatic test_header_mismatch();
		frame_q_t f;
		// Break ethertype, protocol and each port in turn
		for (int unsigned k = 0; k < 5; k++) begin
			f = build_frame(5, want_src, want_dst, 2);
			case (k)
				0: f[POS_ETYPE_LO - 1] ^= 8'h01;
				1: f[POS_ETYPE_LO] ^= 8'h80;
				2: f[POS_PROTO] ^= 8'h02;
				3: f[ETH_HDR_BYTES + IP_HDR_BYTES + 1] ^= 8'h01;
				default: f[ETH_HDR_BYTES + IP_HDR_BYTES + 2] ^= 8'h40;
			endcase
			send_frame(f);
		end
		// Frame ending inside the UDP header, then one ending right at its end
		f = build_frame(5, want_src, want_dst, 0);
		f = f[0:ETH_HDR_BYTES + IP_HDR_BYTES + 2];
		send_frame(f);
		send_frame(build_frame(5, want_src, want_dst, 0));
		send_frame(build_frame(5, want_src, want_dst, 1));
	endtask

	task automatic test_ihl_zero();
		frame_q_t f;
		// Source high byte doubles as the IHL byte, so its low nibble is zero
		write_reg(REG_WANT_SOURCE_PORT, 16'h4012);
		write_reg(REG_WANT_DEST_PORT, 16'h9ABC);
		f = build_frame(0, 16'h4012, 16'h9ABC, 6);
		send_frame(f);
		// IHL one to four: ports overlay the IP header
		for (int unsigned ihl = 1; ihl <= 4; ihl++)
			send_frame(build_frame(ihl, want_src, want_dst, 4));
	endtask

	task automatic test_port_extremes();
		write_reg(REG_WANT_SOURCE_PORT, 16'h0000);
		write_reg(REG_WANT_DEST_PORT, 16'h0000);
		send_frame(build_frame(5, 16'h0000, 16'h0000, 2));
		write_reg(REG_WANT_SOURCE_PORT, 16'hFFFF);
		write_reg(REG_WANT_DEST_PORT, 16'hFFFF);
		send_frame(build_frame(15, 16'hFFFF, 16'hFFFF, 2));
		// A write to an unused index leaves both ports alone
		write_reg(REG_SPARE, 16'h0000);
		send_frame(build_frame(5, 16'hFFFF, 16'hFFFF, 1));
	endtask

	task automatic test_long_frame();
		frame_q_t f;
		// Run past saturation, so the tail and the final byte are dropped
		f = build_frame(5, want_src, want_dst, MAX_FRAME_BYTES + 4 - 42);
		send_frame(f);
		// The next frame must start from a clean header walk
		send_frame(build_frame(5, want_src, want_dst, 3));
	endtask

	task automatic test_random_frames(input int unsigned target);
		frame_q_t    f;
		int unsigned sent;
		int unsigned ihl;
		int unsigned kind;
		int unsigned hs;
		logic [15:0] value;
		sent = 0;
		while (sent < target) begin
			// Change a port now and then, extremes included
			if ($urandom_range(7, 0) == 0) begin
				case ($urandom_range(3, 0))
					0: value = 16'h0000;
					1: value = 16'hFFFF;
					default: value = 16'($urandom);
				endcase
				write_reg($urandom_range(1, 0) ? REG_WANT_DEST_PORT : REG_WANT_SOURCE_PORT,
					value);
			end
			ihl  = ($urandom_range(9, 0) == 0) ? $urandom_range(4, 0) : $urandom_range(15, 5);
			hs   = ETH_HDR_BYTES + 4 * ihl;
			kind = $urandom_range(99, 0);
			f    = build_frame(ihl, want_src, want_dst, $urandom_range(40, 0));
			if (kind >= 85) begin
				// Noise of random length
				f = {};
				repeat ($urandom_range(60, 1)) f.push_back(8'($urandom));
			end else if (kind >= 70) begin
				// Flip one header field
				case ($urandom_range(5, 0))
					0: f[POS_ETYPE_LO - 1] ^= 8'($urandom_range(255, 1));
					1: f[POS_ETYPE_LO] ^= 8'($urandom_range(255, 1));
					2: f[POS_PROTO] ^= 8'($urandom_range(255, 1));
					3: f[hs] ^= 8'($urandom_range(255, 1));
					4: f[hs + 1] ^= 8'($urandom_range(255, 1));
					default: f[hs + 2 + $urandom_range(1, 0)] ^= 8'($urandom_range(255, 1));
				endcase
			end
			send_frame(f);
			sent += f.size();
			// Hold the sender once until the output side has caught up
			if (!paused_once && sent > target / 2) begin
				paused_once = 1'b1;
				drain_payload();
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 16;
		recv_idle_pct = 67;
		test_reset_ports();
		test_header_mismatch();
		test_ihl_zero();
		test_port_extremes();
		test_long_frame();
		test_random_frames(150);

		send_idle_pct = 67;
		recv_idle_pct = 16;
		test_random_frames(150);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_frames(150);

		drain_payload();
		if (fault_count == 0 && payload_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Stop a run that hangs
	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/eupf_pkg.sv
rtl/eupf_cfg_regs.sv
rtl/eupf_in_reg.sv
rtl/eupf_parser.sv
rtl/eupf_out_reg.sv
rtl/eth_ipv4_udp_port_filter.sv
rtl/eupf_checker.sv
dv/tb_top.sv
